FILE: rtl/midpoint_circle_pixel_generator_assert.svh
// Assertion macros for the midpoint circle pixel generator.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef MIDPOINT_CIRCLE_PIXEL_GENERATOR_ASSERT_SVH
`define MIDPOINT_CIRCLE_PIXEL_GENERATOR_ASSERT_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define MCPG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define MCPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mcpg_pkg.sv
// Shared types, widths and codes for the midpoint circle pixel generator.
// No dependencies; used by rtl/midpoint_circle_pixel_generator.sv.
package mcpg_pkg;

  localparam int COORD_W    = 13;  // centre, radius, thickness, step terms
  localparam int PIX_W      = 14;  // signed pixel coordinates
  localparam int DEC_W      = 16;  // midpoint decision term
  localparam int OCT_W      = 3;
  localparam int COLOR_W    = 24;
  localparam int ADDR_W     = 24;
  localparam int DIM_W      = 14;  // effective frame size, holds up to 8192
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = COORD_W'(640);
  localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(480);

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  // Pixel held between the stepping stage and the clipping stage
  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      rgb;
    logic                    last;
  } pix_t;

  // Swap the outer bytes: BGR word to RGB word
  function automatic logic [COLOR_W-1:0] bgr_to_rgb(input logic [COLOR_W-1:0] c);
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

FILE: rtl/midpoint_circle_pixel_generator.sv
// Midpoint circle pixel generator: stepping stage, clipping/address stage, APB registers.
// Depends on rtl/mcpg_pkg.sv and rtl/midpoint_circle_pixel_generator_assert.svh.
//
// A start transfer (tuser = 0) latches centre, radius, thickness and colour and
// gives no pixel. Each tick transfer (tuser = 1) while a command is active gives
// one candidate pixel: eight octant points per midpoint step, rings from the
// outer radius inward, tlast on the final pixel. Ticks while idle are taken and
// dropped. The block takes one transfer per clock unless the output stalls. A pixel
// passes the stepping register, then the clipping and address register, where the
// row-times-width multiply sits. The user must write frame width and height over APB only
// while no command is running and the pipeline is empty; the block does not enforce it.
`include "midpoint_circle_pixel_generator_assert.svh"

module midpoint_circle_pixel_generator #(
  parameter int MAX_DIM = mcpg_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: center_x[12:0], center_y[25:13], radius[38:26], thickness[51:39],
  //        color_bgr[75:52], zero[79:76]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mcpg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: operation[0]
  input  logic                                 s_axis_tuser,
  // tdata: pixel_x[13:0], pixel_y[27:14], pixel_address[51:28],
  //        pixel_rgb[75:52], zero[79:76]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mcpg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: write_enable[0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcpg_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcpg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mcpg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int CW = mcpg_pkg::COORD_W;
  localparam int PW = mcpg_pkg::PIX_W;
  localparam int DW = mcpg_pkg::DEC_W;
  localparam int WW = mcpg_pkg::DIM_W;
  localparam logic [WW-1:0] MaxDim = WW'(MAX_DIM);

  // ---------------------------------------------------------------- registers
  logic [CW-1:0] frame_width_q, frame_height_q;
  logic          cfg_write;
  mcpg_pkg::reg_e cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = mcpg_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mcpg_pkg::WIDTH_RESET;
      frame_height_q <= mcpg_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        mcpg_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CW-1:0];
        mcpg_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mcpg_pkg::REG_FRAME_WIDTH:  prdata = mcpg_pkg::APB_DATA_W'(frame_width_q);
      mcpg_pkg::REG_FRAME_HEIGHT: prdata = mcpg_pkg::APB_DATA_W'(frame_height_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q;
  logic out_ready, s1_ready;
  logic in_xfer, start_xfer, tick_xfer;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign start_xfer    = in_xfer && (s_axis_tuser == mcpg_pkg::OP_START);
  assign tick_xfer     = in_xfer && (s_axis_tuser == mcpg_pkg::OP_TICK);

  // ---------------------------------------------------------------- input fields
  logic signed [CW-1:0]            in_cx, in_cy, in_radius, in_thick;
  logic [mcpg_pkg::COLOR_W-1:0]    in_bgr;

  assign in_cx     = s_axis_tdata[12:0];
  assign in_cy     = s_axis_tdata[25:13];
  assign in_radius = s_axis_tdata[38:26];
  assign in_thick  = s_axis_tdata[51:39];
  assign in_bgr    = s_axis_tdata[75:52];

  // ---------------------------------------------------------------- circle state
  logic                         busy_q, busy_d;
  logic signed [CW-1:0]         centre_col_q, centre_col_d;
  logic signed [CW-1:0]         centre_row_q, centre_row_d;
  logic signed [CW-1:0]         ring_radius_q, ring_radius_d;
  logic signed [CW-1:0]         rings_left_q, rings_left_d;
  logic signed [CW-1:0]         step_x_q, step_x_d;
  logic signed [CW-1:0]         step_y_q, step_y_d;
  logic signed [DW-1:0]         decision_q, decision_d;
  logic [mcpg_pkg::OCT_W-1:0]   octant_q, octant_d;
  logic [mcpg_pkg::COLOR_W-1:0] draw_color_q, draw_color_d;

  logic signed [PW-1:0] oct_a, oct_b, pix_x, pix_y;
  logic signed [DW-1:0] sx_ext, sy_ext;
  logic signed [CW-1:0] nx, ny, rings_dec, radius_dec;
  logic signed [DW-1:0] dec_step;
  logic                 ring_done;
  mcpg_pkg::pix_t       s1_pix_q, s1_pix_d;

  // Octant point: bit 2 swaps x and y, bit 0 mirrors the column, bit 1 the row
  always_comb begin
    oct_a = octant_q[2] ? PW'(step_y_q) : PW'(step_x_q);
    oct_b = octant_q[2] ? PW'(step_x_q) : PW'(step_y_q);
    pix_x = PW'(centre_col_q) + (octant_q[0] ? -oct_a : oct_a);
    pix_y = PW'(centre_row_q) + (octant_q[1] ? -oct_b : oct_b);
  end

  // Midpoint step after the eighth point
  always_comb begin
    sx_ext = DW'(step_x_q);
    sy_ext = DW'(step_y_q);
    if (decision_q < 0) begin
      dec_step = decision_q + (sx_ext <<< 1) + DW'(3);
      ny       = step_y_q;
    end else begin
      dec_step = decision_q + ((sx_ext - sy_ext) <<< 1) + DW'(5);
      ny       = step_y_q - CW'(1);
    end
    nx         = step_x_q + CW'(1);
    ring_done  = nx > ny;
    rings_dec  = rings_left_q - CW'(1);
    radius_dec = ring_radius_q - CW'(1);
  end

  always_comb begin
    busy_d        = busy_q;
    centre_col_d  = centre_col_q;
    centre_row_d  = centre_row_q;
    ring_radius_d = ring_radius_q;
    rings_left_d  = rings_left_q;
    step_x_d      = step_x_q;
    step_y_d      = step_y_q;
    decision_d    = decision_q;
    octant_d      = octant_q;
    draw_color_d  = draw_color_q;
    s1_valid_d    = s1_valid_q && !out_ready;

    if (start_xfer) begin
      // abort anything in progress and load the new command
      centre_col_d  = in_cx;
      centre_row_d  = in_cy;
      ring_radius_d = in_radius;
      rings_left_d  = (in_thick < CW'(1)) ? CW'(1) : in_thick;
      draw_color_d  = mcpg_pkg::bgr_to_rgb(in_bgr);
      step_x_d      = '0;
      step_y_d      = in_radius;
      decision_d    = DW'(1) - DW'(in_radius);
      octant_d      = '0;
      busy_d        = in_radius > CW'(0);
    end else if (tick_xfer && busy_q) begin
      s1_valid_d = 1'b1;
      if (octant_q != '1) begin
        octant_d = octant_q + mcpg_pkg::OCT_W'(1);
      end else begin
        octant_d   = '0;
        decision_d = dec_step;
        step_x_d   = nx;
        step_y_d   = ny;
        if (ring_done) begin
          rings_left_d  = rings_dec;
          ring_radius_d = radius_dec;
          if (rings_dec <= CW'(0) || radius_dec <= CW'(0)) begin
            busy_d = 1'b0;
          end else begin
            step_x_d   = '0;
            step_y_d   = radius_dec;
            decision_d = DW'(1) - DW'(radius_dec);
          end
        end
      end
    end
  end

  always_comb begin
    s1_pix_d.x    = pix_x;
    s1_pix_d.y    = pix_y;
    s1_pix_d.rgb  = draw_color_q;
    s1_pix_d.last = !busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      centre_col_q  <= '0;
      centre_row_q  <= '0;
      ring_radius_q <= '0;
      rings_left_q  <= '0;
      step_x_q      <= '0;
      step_y_q      <= '0;
      decision_q    <= '0;
      octant_q      <= '0;
      draw_color_q  <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      centre_col_q  <= centre_col_d;
      centre_row_q  <= centre_row_d;
      ring_radius_q <= ring_radius_d;
      rings_left_q  <= rings_left_d;
      step_x_q      <= step_x_d;
      step_y_q      <= step_y_d;
      decision_q    <= decision_d;
      octant_q      <= octant_d;
      draw_color_q  <= draw_color_d;
      s1_valid_q    <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer && busy_q) begin
      s1_pix_q <= s1_pix_d;
    end
  end

  // ---------------------------------------------------------------- clip and address
  logic [WW-1:0]                 eff_w, eff_h;
  logic                          in_frame;
  logic [CW+WW-1:0]              row_base;
  logic [mcpg_pkg::ADDR_W-1:0]   addr_d;

  logic signed [PW-1:0]          out_x_q, out_y_q;
  logic [mcpg_pkg::ADDR_W-1:0]   out_addr_q;
  logic [mcpg_pkg::COLOR_W-1:0]  out_rgb_q;
  logic                          out_we_q, out_last_q;

  always_comb begin
    eff_w    = (WW'(frame_width_q) > MaxDim) ? MaxDim : WW'(frame_width_q);
    eff_h    = (WW'(frame_height_q) > MaxDim) ? MaxDim : WW'(frame_height_q);
    in_frame = !s1_pix_q.x[PW-1] && (WW'(s1_pix_q.x[PW-2:0]) < eff_w) &&
               !s1_pix_q.y[PW-1] && (WW'(s1_pix_q.y[PW-2:0]) < eff_h);
    row_base = (CW+WW)'(s1_pix_q.y[PW-2:0]) * (CW+WW)'(eff_w);
    addr_d   = in_frame ? mcpg_pkg::ADDR_W'(row_base + (CW+WW)'(s1_pix_q.x[PW-2:0]))
                        : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_x_q    <= s1_pix_q.x;
      out_y_q    <= s1_pix_q.y;
      out_addr_q <= addr_d;
      out_rgb_q  <= s1_pix_q.rgb;
      out_we_q   <= in_frame;
      out_last_q <= s1_pix_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_rgb_q, out_addr_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- checks
  `MCPG_ASSERT(idle_octant_zero, clk_i, rst_ni, !busy_q |-> octant_q == '0, "octant not cleared while idle")
  `MCPG_ASSERT(ring_in_range, clk_i, rst_ni, busy_q |-> (ring_radius_q > 0 && rings_left_q > 0), "active ring count or radius not positive")
  `MCPG_ASSERT(step_order, clk_i, rst_ni, busy_q |-> step_x_q <= step_y_q, "midpoint step past the octant boundary")
  `MCPG_ASSERT(start_loads_ring, clk_i, rst_ni, start_xfer |=> (octant_q == '0 && step_x_q == '0), "start did not restart the ring")
  `MCPG_ASSERT(clipped_addr_zero, clk_i, rst_ni, (out_valid_q && !out_we_q) |-> out_addr_q == '0, "clipped pixel carries an address")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for midpoint_circle_pixel_generator: circle commands and ticks
// on the input stream, pixels checked against an in-bench circle tracer, APB setup.
// Depends on rtl/mcpg_pkg.sv and rtl/midpoint_circle_pixel_generator.sv.
`timescale 1ns / 1ps

module tb_top;
  import mcpg_pkg::*;

  localparam int ITEMS_PER_PHASE = 172;
  localparam int NUM_PHASES      = 7;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [ADDR_W-1:0]       addr;
    logic [COLOR_W-1:0]      rgb;
    logic                    we;
    logic                    last;
  } pixel_rec_t;

  typedef struct packed {
    op_e                       op;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] rad;
    logic signed [COORD_W-1:0] thick;
    logic [COLOR_W-1:0]        bgr;
    logic                      typed;
    pixel_rec_t                pix;
  } dir_row_t;

  // 13'h1000 is -4096
  localparam dir_row_t DIR_ROWS [23] = '{
    '{OP_START, 13'sd0, 13'sd0, 13'sd1, 13'sd1, 24'h112233, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{14'sd0, 14'sd1, 24'd640, 24'h332211, 1'b1, 1'b0}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{14'sd0, 14'sd1, 24'd640, 24'h332211, 1'b1, 1'b0}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{14'sd0, -14'sd1, 24'd0, 24'h332211, 1'b0, 1'b0}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{-14'sd1, 14'sd0, 24'd0, 24'h332211, 1'b0, 1'b1}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_START, 13'sd100, 13'sd100, 13'sd0, 13'sd5, 24'hFFFFFF, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_START, 13'sd0, 13'sd0, 13'h1000, 13'sd4095, 24'h000000, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_START, 13'sd4095, 13'sd4095, 13'sd4095, 13'h1000, 24'hFFFFFF, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{14'sd4095, 14'sd8190, 24'd0, 24'hFFFFFF, 1'b0, 1'b0}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{14'sd4095, 14'sd8190, 24'd0, 24'hFFFFFF, 1'b0, 1'b0}},
    '{OP_START, 13'h1000, 13'h1000, 13'sd4095, 13'sd4095, 24'h000000, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b1,
      '{-14'sd4096, -14'sd1, 24'd0, 24'h000000, 1'b0, 1'b0}},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_START, 13'sd3, 13'sd2, 13'sd2, 13'sd3, 24'hA5C35A, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0},
    '{OP_TICK, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 24'h0, 1'b0, '0}
  };

  localparam logic [COORD_W-1:0] FRAME_W [NUM_PHASES] = '{640, 1, 4096, 8191, 0, 100, 37};
  localparam logic [COORD_W-1:0] FRAME_H [NUM_PHASES] = '{480, 1, 4096, 8191, 0, 60, 4095};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // center_x, center_y, radius, thickness, color_bgr
  logic                  s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // pixel_x, pixel_y, pixel_address, pixel_rgb
  logic                  m_axis_tuser;   // write_enable
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  midpoint_circle_pixel_generator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Circle tracer state
  logic [COORD_W-1:0] fb_width;
  logic [COORD_W-1:0] fb_height;
  bit                 circle_active;
  int                 ctr_col, ctr_row, ring_r, rings_left, sx, sy, err_term;
  int unsigned        oct;
  logic [COLOR_W-1:0] draw_rgb;

  pixel_rec_t  pending_pixels[$];
  int          mismatches;
  int          items_done;
  int unsigned burst_left;
  bit          rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic advance_circle(input op_e op, input logic [IN_DATA_W-1:0] d,
                                output bit got, output pixel_rec_t p);
    logic signed [COORD_W-1:0] f_t;
    logic [COLOR_W-1:0]        bgr;
    int px, py, w, h;
    got = 1'b0;
    p   = '0;
    if (op == OP_START) begin
      ctr_col    = int'($signed(d[12:0]));
      ctr_row    = int'($signed(d[25:13]));
      ring_r     = int'($signed(d[38:26]));
      f_t        = d[51:39];
      bgr        = d[75:52];
      rings_left = (int'(f_t) < 1) ? 1 : int'(f_t);
      draw_rgb   = {bgr[7:0], bgr[15:8], bgr[23:16]};
      sx = 0; sy = ring_r; err_term = 1 - ring_r; oct = 0;
      circle_active = (ring_r > 0);
    end else if (circle_active) begin
      case (oct)
        0: begin px = ctr_col + sx; py = ctr_row + sy; end
        1: begin px = ctr_col - sx; py = ctr_row + sy; end
        2: begin px = ctr_col + sx; py = ctr_row - sy; end
        3: begin px = ctr_col - sx; py = ctr_row - sy; end
        4: begin px = ctr_col + sy; py = ctr_row + sx; end
        5: begin px = ctr_col - sy; py = ctr_row + sx; end
        6: begin px = ctr_col + sy; py = ctr_row - sx; end
        default: begin px = ctr_col - sy; py = ctr_row - sx; end
      endcase
      // Clip against the frame, saturated at the largest size
      w = (fb_width > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(fb_width);
      h = (fb_height > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(fb_height);
      p.we   = (px >= 0) && (px < w) && (py >= 0) && (py < h);
      p.addr = p.we ? ADDR_W'(py * w + px) : '0;
      if (oct < 7) begin
        oct++;
      end else begin
        oct = 0;
        if (err_term < 0) begin
          err_term += 2 * sx + 3;
        end else begin
          err_term += 2 * (sx - sy) + 5;
          sy--;
        end
        sx++;
        if (sx > sy) begin
          rings_left--;
          ring_r--;
          if (rings_left <= 0 || ring_r <= 0) begin
            circle_active = 1'b0;
          end else begin
            sx = 0; sy = ring_r; err_term = 1 - ring_r;
          end
        end
      end
      p.x    = px[PIX_W-1:0];
      p.y    = py[PIX_W-1:0];
      p.rgb  = draw_rgb;
      p.last = !circle_active;
      got    = 1'b1;
    end
  endtask

  // Offer one transfer in bursts with random gaps, then trace it
  task automatic send_item(input op_e op, input logic [IN_DATA_W-1:0] d,
                           input bit typed, input pixel_rec_t typed_pix);
    int unsigned gap;
    bit          got;
    pixel_rec_t  p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_circle(op, d, got, p);
    if (got) pending_pixels.push_back(typed ? typed_pix : p);
    if (op == OP_START || got) items_done++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_cmd(
      input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
      input logic [COORD_W-1:0] rad, input logic [COORD_W-1:0] thick,
      input logic [COLOR_W-1:0] bgr);
    return {4'b0, bgr, thick, rad, cy, cx};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_word();
    return IN_DATA_W'({$urandom, $urandom, $urandom});
  endfunction

  function automatic logic [COORD_W-1:0] rand13();
    return COORD_W'($urandom);
  endfunction

  // Coordinate within about 20 pixels of the visible frame
  function automatic logic [COORD_W-1:0] near_frame(input logic [COORD_W-1:0] size);
    int eff, v;
    eff = (size > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(size);
    v = int'($urandom_range(0, eff + 39)) - 20;
    if (v > 4095) v = 4095;
    return v[COORD_W-1:0];
  endfunction

  // Abort any running command, then drain the pipeline
  task automatic settle();
    if (circle_active)
      send_item(OP_START, pack_cmd(rand13(), rand13(), '0, rand13(), 24'($urandom)),
                1'b0, '0);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e r, input logic [COORD_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(input reg_e r, input logic [COORD_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(want)) begin
      $error("register %s: expected %0d, got %0d", r.name(), want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_pixel();
    pixel_rec_t              want;
    logic signed [PIX_W-1:0] gx, gy;
    logic [ADDR_W-1:0]       ga;
    logic [COLOR_W-1:0]      gc;
    gx = m_axis_tdata[13:0];
    gy = m_axis_tdata[27:14];
    ga = m_axis_tdata[51:28];
    gc = m_axis_tdata[75:52];
    if (pending_pixels.size() == 0) begin
      $error("pixel with none pending: x=%0d y=%0d", gx, gy);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      if (gx !== want.x) begin
        $error("pixel_x: expected %0d, got %0d", want.x, gx); mismatches++;
      end
      if (gy !== want.y) begin
        $error("pixel_y: expected %0d, got %0d", want.y, gy); mismatches++;
      end
      if (ga !== want.addr) begin
        $error("pixel_address: expected %0d, got %0d", want.addr, ga); mismatches++;
      end
      if (gc !== want.rgb) begin
        $error("pixel_rgb: expected %06h, got %06h", want.rgb, gc); mismatches++;
      end
      if (m_axis_tuser !== want.we) begin
        $error("write_enable: expected %0d, got %0d", want.we, m_axis_tuser); mismatches++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last_pixel: expected %0d, got %0d", want.last, m_axis_tlast); mismatches++;
      end
    end
  endtask

  // Receiver: check each transfer; stall by a rotating pattern or on a hold request
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold_left;
    bit          rdy;
    cyc = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_pixel();
      cyc++;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(1));
          2: rdy = ($urandom_range(3) == 0);
          default: rdy = cyc[0];
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin : stimulus
    int unsigned               kind;
    logic signed [COORD_W-1:0] cx, cy, rad, thick;
    logic [COLOR_W-1:0]        bgr;
    dir_row_t                  row;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_START;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    mismatches    = 0;
    items_done    = 0;
    burst_left    = 0;
    rx_hold_req   = 1'b0;
    fb_width      = WIDTH_RESET;
    fb_height     = HEIGHT_RESET;
    circle_active = 1'b0;
    ctr_col = 0; ctr_row = 0; ring_r = 0; rings_left = 0;
    sx = 0; sy = 0; err_term = 0; oct = 0;
    draw_rgb = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        apb_check(REG_FRAME_WIDTH, WIDTH_RESET);
        apb_check(REG_FRAME_HEIGHT, HEIGHT_RESET);
        foreach (DIR_ROWS[i]) begin
          row = DIR_ROWS[i];
          send_item(row.op, (row.op == OP_START) ?
                    pack_cmd(row.cx, row.cy, row.rad, row.thick, row.bgr) : '0,
                    row.typed, row.pix);
        end
      end else begin
        fb_width  = FRAME_W[ph];
        fb_height = FRAME_H[ph];
        apb_write(REG_FRAME_WIDTH, fb_width);
        apb_write(REG_FRAME_HEIGHT, fb_height);
        apb_check(REG_FRAME_WIDTH, fb_width);
        apb_check(REG_FRAME_HEIGHT, fb_height);
      end
      // Long output stall while input keeps coming: backs the pipeline up
      if (ph == 2) rx_hold_req = 1'b1;

      while (items_done < (ph + 1) * ITEMS_PER_PHASE) begin
        kind = $urandom_range(99);
        bgr  = 24'($urandom);
        if (kind < 65) begin
          // Whole command drawn to its final pixel
          cx = near_frame(fb_width);
          cy = near_frame(fb_height);
          if (kind < 45) begin
            rad   = COORD_W'($urandom_range(1, 6));
            thick = COORD_W'($urandom_range(1, 2));
          end else begin
            rad   = COORD_W'($urandom_range(1, 14));
            thick = ($urandom_range(3) == 0) ? rand13() : COORD_W'($urandom_range(1, 3));
          end
          send_item(OP_START, pack_cmd(cx, cy, rad, thick, bgr), 1'b0, '0);
          while (circle_active) send_item(OP_TICK, rand_word(), 1'b0, '0);
          if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) send_item(OP_TICK, rand_word(), 1'b0, '0);
        end else if (kind < 85) begin
          // Full-range fields, cut short by the next start
          send_item(OP_START, pack_cmd(rand13(), rand13(), rand13(), rand13(), bgr),
                    1'b0, '0);
          repeat ($urandom_range(0, 30)) send_item(OP_TICK, rand_word(), 1'b0, '0);
        end else if (kind < 93) begin
          rad = COORD_W'(-int'($urandom_range(0, 4096)));
          send_item(OP_START, pack_cmd(rand13(), rand13(), rad, rand13(), bgr), 1'b0, '0);
          send_item(OP_TICK, rand_word(), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 3)) send_item(OP_TICK, rand_word(), 1'b0, '0);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
